[src/xsr_pkg.sv]
package xsr_pkg;

	// Operation codes
	typedef enum logic [2:0] {
		CMD_SHL  = 3'd0,
		CMD_SHR  = 3'd1,
		CMD_SAR  = 3'd2,
		CMD_ROL  = 3'd3,
		CMD_ROR  = 3'd4,
		CMD_SHLD = 3'd5,
		CMD_SHRD = 3'd6
	} cmd_t;

	// Flag bit positions
	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_PF = 1;
	localparam int unsigned FLAG_ZF = 2;
	localparam int unsigned FLAG_SF = 3;
	localparam int unsigned FLAG_OF = 4;

	localparam int unsigned FLAGS_W = 5;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned HALF_W  = 32;

	// Count masks for 64-bit and 32-bit operation
	localparam logic [5:0] CNT_MASK64 = 6'h3f;
	localparam logic [5:0] CNT_MASK32 = 6'h1f;

	// Per-request control carried down the pipeline
	typedef struct packed {
		cmd_t                 cmd;
		logic                 wide;
		logic                 pass;
		logic                 one;
		logic                 xtop;
		logic [FLAGS_W-1:0]   flags;
	} ctl_t;

endpackage

[src/x86_shift_rotate_flags_unit.sv]
// An accepted request passes through four registered stages before its result is valid.
// Throughput: one request per cycle; the four stages stall only when the
// result is held and every stage ahead of it is occupied.
// Stages: decode and funnel setup, byte shift, bit shift, result and flags.
// Reset (arst_n low) clears all stage valid bits asynchronously.
module x86_shift_rotate_flags_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [2:0]                    cmd,
	input  logic                          wide,
	input  logic [xsr_pkg::DATA_W-1:0]    operand,
	input  logic [xsr_pkg::DATA_W-1:0]    fill,
	input  logic [7:0]                    count,
	input  logic [xsr_pkg::FLAGS_W-1:0]   flags_in,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [xsr_pkg::DATA_W-1:0]    result,
	output logic [xsr_pkg::FLAGS_W-1:0]   flags_out
);
	import xsr_pkg::*;

	// Pipeline handshake: a stage loads when empty or when the next one moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4      = !v_s4 || !res_stall;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req_stall = !rdy1;
	assign res_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: mask count, pick funnel halves and right-shift amount
	logic [DATA_W-1:0]   x, fi, hi, lo;
	logic [5:0]          cnt;
	logic [6:0]          wbits, lamt;
	logic                sgn, pass, left;
	logic [5:0]          amt;
	logic [2*DATA_W-1:0] cat;
	ctl_t                ctl_d;

	always_comb begin
		x     = wide ? operand : {{HALF_W{1'b0}}, operand[HALF_W-1:0]};
		fi    = wide ? fill : {{HALF_W{1'b0}}, fill[HALF_W-1:0]};
		cnt   = count[5:0] & (wide ? CNT_MASK64 : CNT_MASK32);
		wbits = wide ? 7'd64 : 7'd32;
		lamt  = wbits - {1'b0, cnt};
		sgn   = wide ? operand[DATA_W-1] : operand[HALF_W-1];
		pass  = (cnt == 6'd0) || (cmd > 3'(CMD_SHRD));
		left  = (cmd == 3'(CMD_SHL)) || (cmd == 3'(CMD_SHLD)) || (cmd == 3'(CMD_ROL));
		case (cmd_t'(cmd))
			CMD_SHL:  begin hi = x;              lo = '0; end
			CMD_SHLD: begin hi = x;              lo = fi; end
			CMD_ROL:  begin hi = x;              lo = x;  end
			CMD_ROR:  begin hi = x;              lo = x;  end
			CMD_SHR:  begin hi = '0;             lo = x;  end
			CMD_SAR:  begin hi = {DATA_W{sgn}};  lo = x;  end
			CMD_SHRD: begin hi = fi;             lo = x;  end
			default:  begin hi = '0;             lo = x;  end
		endcase
		if (pass) begin
			cat = {{DATA_W{1'b0}}, x};
			amt = 6'd0;
		end else begin
			cat = wide ? {hi, lo}
			           : {{DATA_W{1'b0}}, hi[HALF_W-1:0], lo[HALF_W-1:0]};
			amt = left ? lamt[5:0] : cnt;
		end
		ctl_d.cmd   = cmd_t'(cmd);
		ctl_d.wide  = wide;
		ctl_d.pass  = pass;
		ctl_d.one   = (cnt == 6'd1);
		ctl_d.xtop  = sgn;
		ctl_d.flags = flags_in;
	end

	logic [2*DATA_W-1:0] cat_s1;
	logic [5:0]          amt_s1;
	ctl_t                ctl_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && req_valid) begin
			cat_s1 <= cat;
			amt_s1 <= amt;
			ctl_s1 <= ctl_d;
		end
	end

	// Stage 2: coarse shift by whole bytes; guard bit below keeps the last bit out
	logic [2*DATA_W:0] grd;
	logic [72:0]       coarse_s2;
	logic [2:0]        fine_s2;
	ctl_t              ctl_s2;

	assign grd = {cat_s1, 1'b0} >> {amt_s1[5:3], 3'b000};

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			coarse_s2 <= grd[72:0];
			fine_s2   <= amt_s1[2:0];
			ctl_s2    <= ctl_s1;
		end
	end

	// Stage 3: fine shift by the low three bits
	logic [72:0] fsh;
	logic [65:0] sh_s3;
	ctl_t        ctl_s3;

	assign fsh = coarse_s2 >> fine_s2;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			sh_s3  <= fsh[65:0];
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: extract result, compute flags, hold for the consumer
	logic [DATA_W-1:0]  r;
	logic               rtop, rtop1, cf, of, rot;
	logic [FLAGS_W-1:0] fl;

	always_comb begin
		r     = ctl_s3.wide ? sh_s3[DATA_W:1] : {{HALF_W{1'b0}}, sh_s3[HALF_W:1]};
		rtop  = ctl_s3.wide ? r[DATA_W-1] : r[HALF_W-1];
		rtop1 = ctl_s3.wide ? r[DATA_W-2] : r[HALF_W-2];
		of    = ctl_s3.flags[FLAG_OF];
		rot   = 1'b0;
		case (ctl_s3.cmd)
			CMD_SHL, CMD_SHLD: begin
				cf = ctl_s3.wide ? sh_s3[DATA_W+1] : sh_s3[HALF_W+1];
				of = ctl_s3.one ? (rtop ^ cf) : 1'b0;
			end
			CMD_SHR: begin
				cf = sh_s3[0];
				if (ctl_s3.one) of = ctl_s3.xtop;
			end
			CMD_SAR: begin
				cf = sh_s3[0];
				if (ctl_s3.one) of = 1'b0;
			end
			CMD_ROL: begin
				rot = 1'b1;
				cf  = r[0];
				if (ctl_s3.one) of = rtop ^ r[0];
			end
			CMD_ROR: begin
				rot = 1'b1;
				cf  = rtop;
				if (ctl_s3.one) of = rtop ^ rtop1;
			end
			default: begin
				cf = sh_s3[0];
				if (ctl_s3.one) of = rtop ^ rtop1;
			end
		endcase
		fl = ctl_s3.flags;
		if (!ctl_s3.pass) begin
			fl[FLAG_CF] = cf;
			fl[FLAG_OF] = of;
			if (!rot) begin
				fl[FLAG_PF] = ~(^r[7:0]);
				fl[FLAG_ZF] = (r == '0);
				fl[FLAG_SF] = rtop;
			end
		end
	end

	logic wide_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			result    <= r;
			flags_out <= fl;
			wide_s4   <= ctl_s3.wide;
		end
	end

`ifndef SYNTHESIS
	// A zero count or unused code must leave the flags untouched
	a_pass_flags: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy4 && ctl_s3.pass |=> flags_out == $past(ctl_s3.flags))
		else $error("pass-through request changed flags");

	// Rotates keep PF, ZF and SF
	a_rot_flags: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy4 && (ctl_s3.cmd == CMD_ROL || ctl_s3.cmd == CMD_ROR)
		|=> flags_out[FLAG_SF:FLAG_PF] == $past(ctl_s3.flags[FLAG_SF:FLAG_PF]))
		else $error("rotate altered PF, ZF or SF");

	// 32-bit results are zero-extended
	a_zext: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !wide_s4 |-> result[DATA_W-1:HALF_W] == '0)
		else $error("32-bit result not zero-extended");

	// An occupied result stage that is stalled blocks the stage behind it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && res_stall && v_s3 |=> v_s3 && v_s4)
		else $error("pipeline dropped a request under stall");
`endif

endmodule
